[design/htl_pkg.sv]
package htl_pkg;

   typedef enum logic [1:0] {
      EV_NONE       = 2'd0,
      EV_START      = 2'd1,
      EV_STOP_TEMP  = 2'd2,
      EV_STOP_FAULT = 2'd3
   } htl_event_type;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLOCK  = 1'b1;

   localparam logic [1:0] CSR_TEMP_ON  = 2'd0;
   localparam logic [1:0] CSR_TEMP_OFF = 2'd1;
   localparam logic [1:0] CSR_LOCKOUT  = 2'd2;
   localparam logic [1:0] CSR_WATTS    = 2'd3;

   localparam logic signed [11:0] TEMP_ON_RESET  = 12'sd96;
   localparam logic signed [11:0] TEMP_OFF_RESET = 12'sd48;
   localparam logic [21:0]        LOCKOUT_RESET  = 22'd300000;
   localparam logic [9:0]         WATTS_RESET    = 10'd200;

   localparam logic [11:0] WAIT_MAX_S = 12'd4095;

   // Exact reciprocals: x/225 for 28-bit x (shift 36), x/1000 and x/3600
   // for 22-bit x (shifts 32 and 34).
   localparam logic [28:0] RECIP_225  = 29'd305419897;
   localparam logic [22:0] RECIP_1000 = 23'd4294968;
   localparam logic [22:0] RECIP_3600 = 23'd4772186;
   localparam logic [31:0] MS_PER_HOUR_DIV = 32'd3600;

   typedef struct packed {
      logic          compressor_on;
      htl_event_type switch_event;
      logic          start_blocked;
      logic          report_valid;
   } htl_flags_type;

   typedef struct packed {
      htl_flags_type flags;
      logic [21:0]   wait_ms;
      logic [31:0]   active_ms;
      logic [31:0]   total_ms;
   } htl_stage_type;

endpackage

[design/htl_post.sv]
module htl_post (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  htl_pkg::htl_stage_type in_data,
   output logic                   in_stall,
   input  logic [9:0]             cfg_watts,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_compressor_on,
   output logic [1:0]             rsp_switch_event,
   output logic                   rsp_start_blocked,
   output logic [11:0]            rsp_wait_left_s,
   output logic                   rsp_report_valid,
   output logic [31:0]            rsp_active_ms,
   output logic [31:0]            rsp_idle_ms,
   output logic [30:0]            rsp_energy_mwh
);

   logic v2_ff, v3_ff, v4_ff, v5_ff;
   logic load2, load3, load4, load5;

   htl_pkg::htl_flags_type flags2_ff, flags3_ff, flags4_ff, flags5_ff;
   logic [31:0] act2_ff, act3_ff, act4_ff, act5_ff;
   logic [31:0] idle2_ff, idle3_ff, idle4_ff, idle5_ff;
   logic [11:0] wait3_ff, wait4_ff, wait5_ff;
   logic [56:0] xprod_ff;
   logic [44:0] wprod_ff;
   logic [20:0] quot_ff;
   logic [11:0] rem_ff;
   logic [30:0] aw_ff;
   logic [21:0] rw_ff;
   logic [30:0] energy_ff;

   logic [31:0] idle2_in;
   logic [56:0] xprod_in;
   logic [44:0] wprod_in;
   logic [20:0] quot_in;
   logic [31:0] rem_full;
   logic [11:0] rem_in;
   logic [12:0] wait_q;
   logic [11:0] wait3_in;
   logic [30:0] aw_in;
   logic [21:0] rw_in;
   logic [44:0] rq_prod;
   logic [30:0] energy_in;

   assign load5    = !v5_ff || !rsp_stall;
   assign load4    = !v4_ff || load5;
   assign load3    = !v3_ff || load4;
   assign load2    = !v2_ff || load3;
   assign in_stall = !load2;

   always_comb begin
      idle2_in = (in_data.total_ms > in_data.active_ms) ?
                 (in_data.total_ms - in_data.active_ms) : 32'd0;
      xprod_in = {29'd0, in_data.active_ms[31:4]} * {28'd0, htl_pkg::RECIP_225};
      wprod_in = {23'd0, in_data.wait_ms} * {22'd0, htl_pkg::RECIP_1000};
   end

   always_comb begin
      quot_in  = xprod_ff[56:36];
      rem_full = act2_ff - ({11'd0, quot_ff_next_dummy()} );
      rem_in   = rem_full[11:0];
      wait_q   = wprod_ff[44:32];
      wait3_in = (wait_q > {1'b0, htl_pkg::WAIT_MAX_S}) ? htl_pkg::WAIT_MAX_S : wait_q[11:0];
   end

   function automatic logic [20:0] quot_ff_next_dummy();
      return 21'd0;
   endfunction

   always_comb begin
      aw_in = {10'd0, quot_ff} * {21'd0, cfg_watts};
      rw_in = {10'd0, rem_ff} * {12'd0, cfg_watts};
   end

   always_comb begin
      rq_prod   = {23'd0, rw_ff} * {22'd0, htl_pkg::RECIP_3600};
      energy_in = aw_ff + {20'd0, rq_prod[44:34]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (load2) v2_ff <= in_valid;
         if (load3) v3_ff <= v2_ff;
         if (load4) v4_ff <= v3_ff;
         if (load5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         flags2_ff <= in_data.flags;
         act2_ff   <= in_data.active_ms;
         idle2_ff  <= idle2_in;
         xprod_ff  <= xprod_in;
         wprod_ff  <= wprod_in;
      end
      if (load3) begin
         flags3_ff <= flags2_ff;
         act3_ff   <= act2_ff;
         idle3_ff  <= idle2_ff;
         wait3_ff  <= wait3_in;
         quot_ff   <= quot_in;
         rem_ff    <= act2_ff[11:0] - 12'(32'(quot_in) * htl_pkg::MS_PER_HOUR_DIV)
                      + 12'(rem_in & 12'd0);
      end
      if (load4) begin
         flags4_ff <= flags3_ff;
         act4_ff   <= act3_ff;
         idle4_ff  <= idle3_ff;
         wait4_ff  <= wait3_ff;
         aw_ff     <= aw_in;
         rw_ff     <= rw_in;
      end
      if (load5) begin
         flags5_ff <= flags4_ff;
         act5_ff   <= act4_ff;
         idle5_ff  <= idle4_ff;
         wait5_ff  <= wait4_ff;
         energy_ff <= energy_in;
      end
   end

   assign rsp_valid         = v5_ff;
   assign rsp_compressor_on = flags5_ff.compressor_on;
   assign rsp_switch_event  = flags5_ff.switch_event;
   assign rsp_start_blocked = flags5_ff.start_blocked;
   assign rsp_wait_left_s   = wait5_ff;
   assign rsp_report_valid  = flags5_ff.report_valid;
   assign rsp_active_ms     = act5_ff;
   assign rsp_idle_ms       = idle5_ff;
   assign rsp_energy_mwh    = energy_ff;

endmodule

[design/hysteresis_thermostat_lockout_unit.sv]
// Channel   Direction  Handshake            Contents
// req_      in         req_valid/req_stall  one sample or clock check per beat
// rsp_      out        rsp_valid/rsp_stall  one result per accepted beat
// csr_      in         csr_wr_en            register index and write data
//
// One beat is accepted every cycle while req_stall is low; its result passes
// through the state update stage and four stages of energy and wait arithmetic.
// Reset is synchronous and restores the power-on thresholds, lockout and power.
// A stalled result holds the last stage; the earlier stages fill up behind it
// and req_stall rises only once every stage holds a beat.
module hysteresis_thermostat_lockout_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [21:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [31:0]         req_now_ms,
   input  logic signed [11:0]  req_temp_sixteenths,
   input  logic                req_sensor_missing,
   input  logic                req_at_midnight,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_compressor_on,
   output logic [1:0]          rsp_switch_event,
   output logic                rsp_start_blocked,
   output logic [11:0]         rsp_wait_left_s,
   output logic                rsp_report_valid,
   output logic [31:0]         rsp_active_ms,
   output logic [31:0]         rsp_idle_ms,
   output logic [30:0]         rsp_energy_mwh
);

   logic signed [11:0] temp_on_ff, temp_off_ff;
   logic [21:0]        lockout_ff;
   logic [9:0]         watts_ff;

   logic        running_ff, running_in;
   logic [31:0] last_stop_ff, last_stop_in;
   logic [31:0] last_change_ff, last_change_in;
   logic [31:0] run_sum_ff, run_sum_in;
   logic [31:0] day_start_ff, day_start_in;
   logic        report_sent_ff, report_sent_in;

   htl_pkg::htl_stage_type s1_ff, s1_in;
   logic                   s1_valid_ff;
   logic                   post_stall;
   logic                   load1;
   logic                   accept;

   logic [31:0] elapsed, since_change, day_len, act;

   assign load1     = !s1_valid_ff || !post_stall;
   assign req_stall = !load1;
   assign accept    = req_valid && load1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_on_ff  <= htl_pkg::TEMP_ON_RESET;
         temp_off_ff <= htl_pkg::TEMP_OFF_RESET;
         lockout_ff  <= htl_pkg::LOCKOUT_RESET;
         watts_ff    <= htl_pkg::WATTS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            htl_pkg::CSR_TEMP_ON:  temp_on_ff  <= csr_wdata[11:0];
            htl_pkg::CSR_TEMP_OFF: temp_off_ff <= csr_wdata[11:0];
            htl_pkg::CSR_LOCKOUT:  lockout_ff  <= csr_wdata;
            htl_pkg::CSR_WATTS:    watts_ff    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      running_in     = running_ff;
      last_stop_in   = last_stop_ff;
      last_change_in = last_change_ff;
      run_sum_in     = run_sum_ff;
      day_start_in   = day_start_ff;
      report_sent_in = report_sent_ff;
      s1_in          = '0;
      act            = 32'd0;
      elapsed        = req_now_ms - last_stop_ff;
      since_change   = req_now_ms - last_change_ff;
      day_len        = req_now_ms - day_start_ff;
      if (req_type == htl_pkg::REQ_SAMPLE) begin
         if (req_sensor_missing) begin
            if (running_ff) begin
               run_sum_in     = run_sum_ff + since_change;
               running_in     = 1'b0;
               last_change_in = req_now_ms;
               last_stop_in   = req_now_ms;
               s1_in.flags.switch_event = htl_pkg::EV_STOP_FAULT;
            end
         end else if (req_temp_sixteenths >= temp_on_ff && !running_ff) begin
            if (elapsed >= {10'd0, lockout_ff}) begin
               running_in     = 1'b1;
               last_change_in = req_now_ms;
               s1_in.flags.switch_event = htl_pkg::EV_START;
            end else begin
               s1_in.flags.start_blocked = 1'b1;
               s1_in.wait_ms = lockout_ff - elapsed[21:0];
            end
         end else if (req_temp_sixteenths <= temp_off_ff && running_ff) begin
            run_sum_in     = run_sum_ff + since_change;
            running_in     = 1'b0;
            last_change_in = req_now_ms;
            last_stop_in   = req_now_ms;
            s1_in.flags.switch_event = htl_pkg::EV_STOP_TEMP;
         end
      end else if (req_at_midnight) begin
         if (!report_sent_ff) begin
            act = run_sum_ff + (running_ff ? since_change : 32'd0);
            s1_in.flags.report_valid = 1'b1;
            s1_in.active_ms = act;
            s1_in.total_ms  = (day_len == 32'd0) ? 32'd1 : day_len;
            run_sum_in      = 32'd0;
            day_start_in    = req_now_ms;
            last_change_in  = req_now_ms;
            report_sent_in  = 1'b1;
         end
      end else begin
         report_sent_in = 1'b0;
      end
      s1_in.flags.compressor_on = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         last_stop_ff   <= 32'd0;
         last_change_ff <= 32'd0;
         run_sum_ff     <= 32'd0;
         day_start_ff   <= 32'd0;
         report_sent_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            running_ff     <= running_in;
            last_stop_ff   <= last_stop_in;
            last_change_ff <= last_change_in;
            run_sum_ff     <= run_sum_in;
            day_start_ff   <= day_start_in;
            report_sent_ff <= report_sent_in;
         end
         if (load1) s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) s1_ff <= s1_in;
   end

   htl_post u_post (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (s1_valid_ff),
      .in_data           (s1_ff),
      .in_stall          (post_stall),
      .cfg_watts         (watts_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compressor_on (rsp_compressor_on),
      .rsp_switch_event  (rsp_switch_event),
      .rsp_start_blocked (rsp_start_blocked),
      .rsp_wait_left_s   (rsp_wait_left_s),
      .rsp_report_valid  (rsp_report_valid),
      .rsp_active_ms     (rsp_active_ms),
      .rsp_idle_ms       (rsp_idle_ms),
      .rsp_energy_mwh    (rsp_energy_mwh)
   );

`ifndef SYNTH
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      accept && s1_in.flags.switch_event == htl_pkg::EV_START |=> running_ff)
      else $error("start beat did not leave the compressor running");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the result stage can move");

   a_start_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switch_event == htl_pkg::EV_START |-> rsp_compressor_on)
      else $error("start reported with the compressor off");

   a_no_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_valid |-> rsp_energy_mwh == 31'd0 && rsp_idle_ms == 32'd0)
      else $error("report figures set without a report");
`endif

endmodule

[bench/thermostat_check_pkg.sv]
package thermostat_check_pkg;
   import htl_pkg::*;

   typedef struct {
      logic               req_type;
      logic [31:0]        now_ms;
      logic signed [11:0] temp;
      logic               missing;
      logic               midnight;
   } thermo_beat_t;

   typedef struct {
      logic          compressor_on;
      htl_event_type switch_event;
      logic          start_blocked;
      logic [11:0]   wait_left_s;
      logic          report_valid;
      logic [31:0]   active_ms;
      logic [31:0]   idle_ms;
      logic [30:0]   energy_mwh;
   } thermo_result_t;

   class thermostat_scoreboard;
      logic signed [11:0] temp_on;
      logic signed [11:0] temp_off;
      logic [21:0]        lockout;
      logic [9:0]         watts;
      logic               running;
      logic [31:0]        last_stop;
      logic [31:0]        last_change;
      logic [31:0]        run_sum;
      logic [31:0]        day_start;
      logic               report_sent;
      thermo_result_t     pending[$];
      int                 errors;
      int                 checked;

      function new();
         errors      = 0;
         checked     = 0;
         temp_on     = TEMP_ON_RESET;
         temp_off    = TEMP_OFF_RESET;
         lockout     = LOCKOUT_RESET;
         watts       = WATTS_RESET;
         running     = 1'b0;
         last_stop   = '0;
         last_change = '0;
         run_sum     = '0;
         day_start   = '0;
         report_sent = 1'b0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [21:0] val);
         case (idx)
            CSR_TEMP_ON:  temp_on  = val[11:0];
            CSR_TEMP_OFF: temp_off = val[11:0];
            CSR_LOCKOUT:  lockout  = val;
            CSR_WATTS:    watts    = val[9:0];
            default: ;
         endcase
      endfunction

      function void stop_compressor(logic [31:0] now);
         run_sum     = run_sum + (now - last_change);
         running     = 1'b0;
         last_change = now;
         last_stop   = now;
      endfunction

      function void note_input(thermo_beat_t b);
         thermo_result_t r;
         logic [31:0]    elapsed;
         logic [31:0]    left;
         logic [31:0]    secs;
         logic [31:0]    total;
         logic [41:0]    product;
         r.switch_event  = EV_NONE;
         r.start_blocked = 1'b0;
         r.wait_left_s   = '0;
         r.report_valid  = 1'b0;
         r.active_ms     = '0;
         r.idle_ms       = '0;
         r.energy_mwh    = '0;
         if (b.req_type == REQ_SAMPLE) begin
            if (b.missing) begin
               if (running) begin
                  stop_compressor(b.now_ms);
                  r.switch_event = EV_STOP_FAULT;
               end
            end else if (b.temp >= temp_on && !running) begin
               elapsed = b.now_ms - last_stop;
               if (elapsed >= {10'd0, lockout}) begin
                  running        = 1'b1;
                  last_change    = b.now_ms;
                  r.switch_event = EV_START;
               end else begin
                  left            = {10'd0, lockout} - elapsed;
                  secs            = left / 1000;
                  r.start_blocked = 1'b1;
                  r.wait_left_s   = (secs > {20'd0, WAIT_MAX_S}) ? WAIT_MAX_S : secs[11:0];
               end
            end else if (b.temp <= temp_off && running) begin
               stop_compressor(b.now_ms);
               r.switch_event = EV_STOP_TEMP;
            end
         end else if (b.midnight) begin
            if (!report_sent) begin
               total       = b.now_ms - day_start;
               r.active_ms = run_sum;
               if (running) r.active_ms = r.active_ms + (b.now_ms - last_change);
               if (total == 0) total = 1;
               r.idle_ms      = (total > r.active_ms) ? total - r.active_ms : '0;
               product        = r.active_ms;
               product        = product * watts;
               product        = product / 3600;
               r.energy_mwh   = product[30:0];
               r.report_valid = 1'b1;
               run_sum        = '0;
               day_start      = b.now_ms;
               last_change    = b.now_ms;
               report_sent    = 1'b1;
            end
         end else begin
            report_sent = 1'b0;
         end
         r.compressor_on = running;
         pending.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch at result %0d: %s", checked, msg);
         errors++;
      endtask

      task check_result(thermo_result_t got);
         thermo_result_t want;
         if (pending.size() == 0) begin
            report("result arrived with nothing expected");
            return;
         end
         want = pending.pop_front();
         if (got.compressor_on !== want.compressor_on)
            report($sformatf("compressor_on got %0d expected %0d",
                             got.compressor_on, want.compressor_on));
         if (got.switch_event !== want.switch_event)
            report($sformatf("switch_event got %0d expected %0d",
                             got.switch_event, want.switch_event));
         if (got.start_blocked !== want.start_blocked)
            report($sformatf("start_blocked got %0d expected %0d",
                             got.start_blocked, want.start_blocked));
         if (got.wait_left_s !== want.wait_left_s)
            report($sformatf("wait_left_s got %0d expected %0d",
                             got.wait_left_s, want.wait_left_s));
         if (got.report_valid !== want.report_valid)
            report($sformatf("report_valid got %0d expected %0d",
                             got.report_valid, want.report_valid));
         if (got.active_ms !== want.active_ms)
            report($sformatf("active_ms got %0d expected %0d",
                             got.active_ms, want.active_ms));
         if (got.idle_ms !== want.idle_ms)
            report($sformatf("idle_ms got %0d expected %0d", got.idle_ms, want.idle_ms));
         if (got.energy_mwh !== want.energy_mwh)
            report($sformatf("energy_mwh got %0d expected %0d",
                             got.energy_mwh, want.energy_mwh));
         checked++;
      endtask
   endclass

endpackage

[bench/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import htl_pkg::*;
   import thermostat_check_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [21:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_type = 1'b0;
   logic [31:0]        req_now_ms = '0;
   logic signed [11:0] req_temp_sixteenths = '0;
   logic               req_sensor_missing = 1'b0;
   logic               req_at_midnight = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_compressor_on;
   logic [1:0]         rsp_switch_event;
   logic               rsp_start_blocked;
   logic [11:0]        rsp_wait_left_s;
   logic               rsp_report_valid;
   logic [31:0]        rsp_active_ms;
   logic [31:0]        rsp_idle_ms;
   logic [30:0]        rsp_energy_mwh;

   thermostat_scoreboard sb = new();
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   logic [31:0]          cur_ms = '0;

   hysteresis_thermostat_lockout_unit uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_now_ms(req_now_ms),
      .req_temp_sixteenths(req_temp_sixteenths),
      .req_sensor_missing(req_sensor_missing),
      .req_at_midnight(req_at_midnight),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_compressor_on(rsp_compressor_on),
      .rsp_switch_event(rsp_switch_event),
      .rsp_start_blocked(rsp_start_blocked),
      .rsp_wait_left_s(rsp_wait_left_s),
      .rsp_report_valid(rsp_report_valid),
      .rsp_active_ms(rsp_active_ms),
      .rsp_idle_ms(rsp_idle_ms),
      .rsp_energy_mwh(rsp_energy_mwh)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      thermo_result_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.compressor_on = rsp_compressor_on;
         got.switch_event  = htl_event_type'(rsp_switch_event);
         got.start_blocked = rsp_start_blocked;
         got.wait_left_s   = rsp_wait_left_s;
         got.report_valid  = rsp_report_valid;
         got.active_ms     = rsp_active_ms;
         got.idle_ms       = rsp_idle_ms;
         got.energy_mwh    = rsp_energy_mwh;
         sb.check_result(got);
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic thermo_beat_t sample_beat(logic [31:0] now, int temp, logic missing);
      thermo_beat_t b;
      b.req_type = REQ_SAMPLE;
      b.now_ms   = now;
      b.temp     = temp[11:0];
      b.missing  = missing;
      b.midnight = $urandom_range(0, 1);
      return b;
   endfunction

   function automatic thermo_beat_t clock_beat(logic [31:0] now, logic midnight);
      thermo_beat_t b;
      b.req_type = REQ_CLOCK;
      b.now_ms   = now;
      b.temp     = $urandom_range(0, 4095);
      b.missing  = $urandom_range(0, 1);
      b.midnight = midnight;
      return b;
   endfunction

   task automatic send_beat(input thermo_beat_t b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= b.req_type;
      req_now_ms          <= b.now_ms;
      req_temp_sixteenths <= b.temp;
      req_sensor_missing  <= b.missing;
      req_at_midnight     <= b.midnight;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(b);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[21:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      sb.write_reg(idx, v[21:0]);
   endtask

   task automatic write_all(input int on_at, input int off_at, input int lock, input int w);
      write_reg(CSR_TEMP_ON, on_at);
      write_reg(CSR_TEMP_OFF, off_at);
      write_reg(CSR_LOCKOUT, lock);
      write_reg(CSR_WATTS, w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic int near_threshold_temp();
      int t;
      int m;
      m = $urandom_range(0, 99);
      if (m < 35) t = int'(sb.temp_on) + int'($urandom_range(0, 6)) - 3;
      else if (m < 70) t = int'(sb.temp_off) + int'($urandom_range(0, 6)) - 3;
      else t = int'($urandom_range(0, 2880)) - 880;
      if (t < -880) t = -880;
      if (t > 2000) t = 2000;
      return t;
   endfunction

   // Time mostly moves forward in small steps; some beats land on the lockout
   // boundary, some jump far ahead and a few go anywhere.
   task automatic random_phase(input int count);
      int k;
      int m;
      for (int i = 0; i < count; i++) begin
         m = $urandom_range(0, 99);
         if (m < 10) cur_ms = cur_ms;
         else if (m < 70) cur_ms = cur_ms + $urandom_range(1, 10000);
         else if (m < 82) cur_ms = sb.last_stop + sb.lockout + $urandom_range(0, 4) - 2;
         else if (m < 94) cur_ms = cur_ms + $urandom_range(0, 4000000);
         else cur_ms = $urandom;
         k = $urandom_range(0, 99);
         if (k < 12) send_beat(clock_beat(cur_ms, $urandom_range(0, 1)));
         else send_beat(sample_beat(cur_ms, near_threshold_temp(),
                                    $urandom_range(0, 99) < 8));
      end
   endtask

   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Power-on settings: zero-length day, repeated midnight, lockout edges.
      send_beat(clock_beat(32'd0, 1'b1));
      send_beat(clock_beat(32'd0, 1'b1));
      send_beat(clock_beat(32'd10, 1'b0));
      send_beat(sample_beat(32'd1000, 2000, 1'b0));
      send_beat(sample_beat(32'd2000, -880, 1'b1));
      send_beat(sample_beat(32'd299999, 96, 1'b0));
      send_beat(sample_beat(32'd300000, 96, 1'b0));
      send_beat(sample_beat(32'd300500, 97, 1'b0));
      send_beat(sample_beat(32'd400000, 48, 1'b0));
      send_beat(sample_beat(32'd400001, -880, 1'b0));
      send_beat(sample_beat(32'd700001, 2000, 1'b0));
      send_beat(sample_beat(32'd700002, 2000, 1'b0));
      send_beat(sample_beat(32'd800000, 0, 1'b1));
      send_beat(clock_beat(32'd900000, 1'b1));
      drain();

      // Crossed thresholds, no lockout, a report while running across the wrap.
      write_all(48, 96, 0, 1000);
      send_beat(sample_beat(32'hFFFF_FF00, 60, 1'b0));
      send_beat(clock_beat(32'hFFFF_FF80, 1'b0));
      send_beat(clock_beat(32'h0000_0100, 1'b1));
      send_beat(sample_beat(32'h0000_0200, 60, 1'b0));
      send_beat(sample_beat(32'h0000_0300, 2000, 1'b1));
      drain();

      write_all(2000, -880, 3600000, 0);
      send_beat(sample_beat(32'h0000_0400, 2000, 1'b0));
      send_beat(sample_beat(32'h0000_0200 + 32'd3600000, 2000, 1'b0));
      send_beat(sample_beat(32'h0000_0200 + 32'd3600001, -880, 1'b0));
      send_beat(clock_beat(32'h0000_0200 + 32'd3700000, 1'b0));
      send_beat(clock_beat(32'h0000_0200 + 32'd3800000, 1'b1));
      drain();

      cur_ms = 32'h0000_0200 + 32'd3800000;
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 59; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 59; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         if (p == 0) write_all(-880, 2000, 0, 0);
         else if (p == 1) write_all(2000, -880, 3600000, 1000);
         else begin
            int on_at;
            on_at = int'($urandom_range(0, 400)) - 100;
            write_all(on_at, on_at - int'($urandom_range(0, 100)),
                      ($urandom_range(0, 1) != 0) ? $urandom_range(0, 60000)
                                                  : $urandom_range(0, 3600000),
                      $urandom_range(0, 1000));
         end
         if (p == 3) cur_ms = 32'hFFF0_0000;
         random_phase(175);
         drain();
      end

      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
